@@ sv/vrt_pkg.sv @@
// Shared constants and types for the voxel ray traversal block.
`default_nettype none
package vrt_pkg;
   localparam int CoordBits = 16;
   localparam int DistFracBits = 16;
   localparam int DistBits = 32;
   localparam int StepBits = 10;
   localparam int FaceBits = 3;
   localparam int StatusBits = 2;
   // Dividend and divisor widths for setup divisions
   localparam int DivBits = 48;
   localparam int MagBits = 16;

   localparam logic [StatusBits-1:0] STATUS_QUERY = 2'd0;
   localparam logic [StatusBits-1:0] STATUS_HIT = 2'd1;
   localparam logic [StatusBits-1:0] STATUS_MISS = 2'd2;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_ANSWER = 1'b1;

   localparam logic [FaceBits-1:0] FACE_POS_Y = 3'd3;
   localparam logic [StepBits-1:0] MAX_STEPS_RESET = 10'd200;

   // Register byte addresses
   localparam logic [1:0] REG_MAX_STEPS = 2'd0;

   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS = 2'd1;
   localparam logic [1:0] SIGN_NEG = 2'd3;

   // One queued input item
   typedef struct packed {
      logic kind;
      logic [31:0] origin_x;
      logic [31:0] origin_y;
      logic [31:0] origin_z;
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [15:0] dir_z;
      logic [DistBits-1:0] max_distance;
      logic cell_hit;
      logic [DistBits-1:0] cell_hit_distance;
      logic [FaceBits-1:0] cell_face;
   } item_type;

   // One result item
   typedef struct packed {
      logic [StatusBits-1:0] status;
      logic [15:0] voxel_x;
      logic [15:0] voxel_y;
      logic [15:0] voxel_z;
      logic [15:0] previous_x;
      logic [15:0] previous_y;
      logic [15:0] previous_z;
      logic [FaceBits-1:0] entry_face;
      logic [DistBits-1:0] hit_distance;
   } result_type;
endpackage
`default_nettype wire

@@ sv/vrt_front.sv @@
// Front end: input queue that holds items for the traversal engine.
`default_nettype none
module vrt_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire vrt_pkg::item_type push_item,
   output logic item_valid,
   input wire logic item_take,
   output vrt_pkg::item_type item
);
   // Two-entry queue
   vrt_pkg::item_type slot_ff [2];
   logic rd_ptr_ff, rd_ptr_in;
   logic wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = item_take && item_valid;

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

@@ sv/vrt_divider.sv @@
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
`default_nettype none
module vrt_divider (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [vrt_pkg::DivBits-1:0] dividend,
   input wire logic [vrt_pkg::MagBits-1:0] divisor,
   output logic done,
   output logic [vrt_pkg::DistBits-1:0] quotient
);
   localparam int CntBits = $clog2(vrt_pkg::DivBits + 1);
   logic [vrt_pkg::DivBits-1:0] quo_ff, quo_in;
   logic [vrt_pkg::MagBits:0] rem_ff, rem_in;
   logic [vrt_pkg::MagBits-1:0] div_ff, div_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [vrt_pkg::MagBits:0] trial;

   assign done = busy_ff && (cnt_ff == CntBits'(0));
   assign quotient = (quo_ff[vrt_pkg::DivBits-1:vrt_pkg::DistBits] != '0) ?
                     '1 : quo_ff[vrt_pkg::DistBits-1:0];

   always_comb begin
      trial = {rem_ff[vrt_pkg::MagBits-1:0], quo_ff[vrt_pkg::DivBits-1]};
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CntBits'(vrt_pkg::DivBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == CntBits'(0)) begin
            busy_in = 1'b0;
         end else begin
            // Shift in next dividend bit, subtract when it fits
            if (trial >= {1'b0, div_ff}) begin
               rem_in = trial - {1'b0, div_ff};
               quo_in = {quo_ff[vrt_pkg::DivBits-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[vrt_pkg::DivBits-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CntBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end
endmodule
`default_nettype wire

@@ sv/vrt_back.sv @@
// Back end: ray setup through the divider, then one DDA step per miss answer.
`default_nettype none
module vrt_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic [vrt_pkg::StepBits-1:0] max_steps,
   input wire logic item_valid,
   output logic item_take,
   input wire vrt_pkg::item_type item,
   output logic rsp_valid,
   input wire logic rsp_take,
   output vrt_pkg::result_type rsp
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_STEP = 3'd4;
   localparam int CB = vrt_pkg::CoordBits;
   localparam int DB = vrt_pkg::DistBits;

   logic [2:0] state_ff, state_in;
   logic [CB-1:0] cur_ff [3];
   logic [CB-1:0] prev_ff [3];
   logic [1:0] sign_ff [3];
   logic [DB-1:0] nb_ff [3];
   logic [DB-1:0] sp_ff [3];
   logic [DB-1:0] trav_ff, limit_ff;
   logic [vrt_pkg::StepBits-1:0] steps_ff;
   logic [vrt_pkg::FaceBits-1:0] face_ff;
   logic active_ff;
   vrt_pkg::item_type held_ff;
   // Division sequencing: axis and which quantity
   logic [1:0] axis_ff;
   logic phase_ff;
   logic out_valid_ff;
   vrt_pkg::result_type out_ff;

   logic div_start, div_done;
   logic [vrt_pkg::DivBits-1:0] div_num;
   logic [vrt_pkg::MagBits-1:0] div_den;
   logic [DB-1:0] div_q;

   logic [31:0] org_sel;
   logic [15:0] dir_sel;
   logic [15:0] mag;
   logic [16:0] bd;
   logic [1:0] pick;
   logic [DB:0] nb_sum;

   vrt_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   // Operands for current setup axis
   always_comb begin
      unique case (axis_ff)
         2'd0: begin org_sel = held_ff.origin_x; dir_sel = held_ff.dir_x; end
         2'd1: begin org_sel = held_ff.origin_y; dir_sel = held_ff.dir_y; end
         default: begin org_sel = held_ff.origin_z; dir_sel = held_ff.dir_z; end
      endcase
      mag = dir_sel[15] ? (16'd0 - dir_sel) : dir_sel;
      bd = dir_sel[15] ? {1'b0, org_sel[15:0]} : (17'h10000 - {1'b0, org_sel[15:0]});
      div_den = mag;
      if (!phase_ff) begin
         div_num = vrt_pkg::DivBits'({bd, (vrt_pkg::DistFracBits - 1)'(0)});
      end else begin
         div_num = vrt_pkg::DivBits'(64'd1 << (vrt_pkg::DistFracBits + 15));
      end
   end

   // Axis with smallest next boundary; x only when strictly smallest, a y/z tie goes to z
   always_comb begin
      if (nb_ff[0] < nb_ff[1] && nb_ff[0] < nb_ff[2]) pick = 2'd0;
      else if (nb_ff[1] < nb_ff[2]) pick = 2'd1;
      else pick = 2'd2;
      nb_sum = {1'b0, nb_ff[pick]} + {1'b0, sp_ff[pick]};
   end

   assign item_take = (state_ff == ST_IDLE) && item_valid && !out_valid_ff;
   assign div_start = (state_ff == ST_DIV) && (dir_sel != 16'd0);
   assign rsp_valid = out_valid_ff;
   assign rsp = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_take) begin
               if (item.kind == vrt_pkg::KIND_START) state_in = ST_DIV;
               else if (active_ff && !item.cell_hit) state_in = ST_STEP;
            end
         end
         ST_DIV: state_in = (dir_sel == 16'd0) ?
                  ((axis_ff == 2'd2) ? ST_EMIT : ST_DIV) : ST_WAIT;
         ST_WAIT: begin
            if (div_done) begin
               state_in = (phase_ff && axis_ff == 2'd2) ? ST_EMIT : ST_DIV;
            end
         end
         ST_STEP: state_in = ST_EMIT;
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         steps_ff <= '0;
         face_ff <= vrt_pkg::FACE_POS_Y;
         trav_ff <= '0;
         limit_ff <= '0;
         axis_ff <= 2'd0;
         phase_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            cur_ff[a] <= '0;
            prev_ff[a] <= '0;
            sign_ff[a] <= vrt_pkg::SIGN_ZERO;
            nb_ff[a] <= '0;
            sp_ff[a] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_take && out_valid_ff) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (item_take) begin
                  held_ff <= item;
                  axis_ff <= 2'd0;
                  phase_ff <= 1'b0;
                  if (item.kind == vrt_pkg::KIND_START) begin
                     trav_ff <= '0;
                     limit_ff <= item.max_distance;
                     steps_ff <= '0;
                     face_ff <= vrt_pkg::FACE_POS_Y;
                     active_ff <= 1'b1;
                  end else if (active_ff && item.cell_hit) begin
                     active_ff <= 1'b0;
                     out_valid_ff <= 1'b1;
                     out_ff.status <= vrt_pkg::STATUS_HIT;
                     out_ff.voxel_x <= 16'(cur_ff[0]);
                     out_ff.voxel_y <= 16'(cur_ff[1]);
                     out_ff.voxel_z <= 16'(cur_ff[2]);
                     out_ff.previous_x <= 16'(prev_ff[0]);
                     out_ff.previous_y <= 16'(prev_ff[1]);
                     out_ff.previous_z <= 16'(prev_ff[2]);
                     out_ff.entry_face <= item.cell_face;
                     out_ff.hit_distance <= item.cell_hit_distance;
                  end
               end
            end
            ST_DIV: begin
               // Voxel, sign per axis; zero axes saturate without dividing
               cur_ff[axis_ff] <= CB'(org_sel[31:16]);
               prev_ff[axis_ff] <= CB'(org_sel[31:16]);
               if (dir_sel == 16'd0) begin
                  sign_ff[axis_ff] <= vrt_pkg::SIGN_ZERO;
                  nb_ff[axis_ff] <= '1;
                  sp_ff[axis_ff] <= '1;
                  axis_ff <= axis_ff + 2'd1;
                  phase_ff <= 1'b0;
               end else begin
                  sign_ff[axis_ff] <= dir_sel[15] ? vrt_pkg::SIGN_NEG : vrt_pkg::SIGN_POS;
               end
            end
            ST_WAIT: begin
               if (div_done) begin
                  if (!phase_ff) begin
                     nb_ff[axis_ff] <= div_q;
                     phase_ff <= 1'b1;
                  end else begin
                     sp_ff[axis_ff] <= div_q;
                     phase_ff <= 1'b0;
                     axis_ff <= axis_ff + 2'd1;
                  end
               end
            end
            ST_STEP: begin
               for (int a = 0; a < 3; a++) prev_ff[a] <= cur_ff[a];
               trav_ff <= nb_ff[pick];
               if (sign_ff[pick] == vrt_pkg::SIGN_POS) cur_ff[pick] <= cur_ff[pick] + CB'(1);
               else if (sign_ff[pick] == vrt_pkg::SIGN_NEG)
                  cur_ff[pick] <= cur_ff[pick] - CB'(1);
               nb_ff[pick] <= nb_sum[DB] ? '1 : nb_sum[DB-1:0];
               face_ff <= {pick, (sign_ff[pick] == vrt_pkg::SIGN_POS) ? 1'b0 : 1'b1};
               steps_ff <= steps_ff + vrt_pkg::StepBits'(1);
            end
            ST_EMIT: begin
               out_valid_ff <= 1'b1;
               out_ff.voxel_x <= 16'(cur_ff[0]);
               out_ff.voxel_y <= 16'(cur_ff[1]);
               out_ff.voxel_z <= 16'(cur_ff[2]);
               out_ff.previous_x <= 16'(prev_ff[0]);
               out_ff.previous_y <= 16'(prev_ff[1]);
               out_ff.previous_z <= 16'(prev_ff[2]);
               out_ff.entry_face <= face_ff;
               out_ff.hit_distance <= '0;
               if (steps_ff < max_steps && trav_ff < limit_ff) begin
                  out_ff.status <= vrt_pkg::STATUS_QUERY;
               end else begin
                  out_ff.status <= vrt_pkg::STATUS_MISS;
                  active_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ sv/voxel_ray_traversal.sv @@
// Top level of the voxel ray traversal block.
`default_nettype none
// Walks the voxels of a ray by 3D DDA. Items enter through a two-entry queue
// and a result register decouples the output; the back end takes no new item
// while a result waits. A miss answer passes through the take, the
// compare-and-add step and the result load; a hit answer loads its result in
// the cycle it is taken. A start item runs two restoring divisions per nonzero
// direction axis on one shared divider, each an issue, the quotient bits and a
// done. max_steps lies at register byte address 0.
module voxel_ray_traversal (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire logic req_kind,
   input wire logic [31:0] req_origin_x,
   input wire logic [31:0] req_origin_y,
   input wire logic [31:0] req_origin_z,
   input wire logic [15:0] req_dir_x,
   input wire logic [15:0] req_dir_y,
   input wire logic [15:0] req_dir_z,
   input wire logic [31:0] req_max_distance,
   input wire logic req_cell_hit,
   input wire logic [31:0] req_cell_hit_distance,
   input wire logic [2:0] req_cell_face,
   output logic empty,
   input wire logic pop,
   output logic [1:0] rsp_status,
   output logic [15:0] rsp_voxel_x,
   output logic [15:0] rsp_voxel_y,
   output logic [15:0] rsp_voxel_z,
   output logic [15:0] rsp_previous_x,
   output logic [15:0] rsp_previous_y,
   output logic [15:0] rsp_previous_z,
   output logic [2:0] rsp_entry_face,
   output logic [31:0] rsp_hit_distance,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [1:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   vrt_pkg::item_type in_item, q_item;
   vrt_pkg::result_type res;
   logic q_valid, q_take, r_valid;
   logic [vrt_pkg::StepBits-1:0] max_steps_ff;

   // Configuration register
   assign pready = 1'b1;
   assign prdata = (paddr == vrt_pkg::REG_MAX_STEPS) ? {22'd0, max_steps_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_steps_ff <= vrt_pkg::MAX_STEPS_RESET;
      end else if (psel && penable && pwrite && paddr == vrt_pkg::REG_MAX_STEPS) begin
         max_steps_ff <= pwdata[vrt_pkg::StepBits-1:0];
      end
   end

   always_comb begin
      in_item.kind = req_kind;
      in_item.origin_x = req_origin_x;
      in_item.origin_y = req_origin_y;
      in_item.origin_z = req_origin_z;
      in_item.dir_x = req_dir_x;
      in_item.dir_y = req_dir_y;
      in_item.dir_z = req_dir_z;
      in_item.max_distance = req_max_distance;
      in_item.cell_hit = req_cell_hit;
      in_item.cell_hit_distance = req_cell_hit_distance;
      in_item.cell_face = req_cell_face;
   end

   vrt_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .push_item(in_item),
      .item_valid(q_valid), .item_take(q_take), .item(q_item)
   );

   vrt_back u_back (
      .clock(clock), .reset(reset), .max_steps(max_steps_ff), .item_valid(q_valid),
      .item_take(q_take), .item(q_item), .rsp_valid(r_valid), .rsp_take(pop), .rsp(res)
   );

   assign empty = !r_valid;
   assign rsp_status = res.status;
   assign rsp_voxel_x = res.voxel_x;
   assign rsp_voxel_y = res.voxel_y;
   assign rsp_voxel_z = res.voxel_z;
   assign rsp_previous_x = res.previous_x;
   assign rsp_previous_y = res.previous_y;
   assign rsp_previous_z = res.previous_z;
   assign rsp_entry_face = res.entry_face;
   assign rsp_hit_distance = res.hit_distance;
endmodule
`default_nettype wire

@@ sv/vrt_checker.sv @@
// Port-level checks for the voxel ray traversal block, bound to the top level.
`default_nettype none
module vrt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic empty,
   input wire logic pop,
   input wire logic [1:0] rsp_status,
   input wire logic [31:0] rsp_hit_distance,
   input wire logic pready
);
   // Held result stays put until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_status))
      else $error("result changed while stalled");
   // Status never takes the unused code
   a_status: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status == vrt_pkg::STATUS_QUERY || rsp_status == vrt_pkg::STATUS_HIT
                  || rsp_status == vrt_pkg::STATUS_MISS))
      else $error("bad status");
   // Distance only carried on a hit
   a_dist: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status != vrt_pkg::STATUS_HIT |-> rsp_hit_distance == 32'd0)
      else $error("distance on non-hit");
   a_ready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule
bind voxel_ray_traversal vrt_checker u_vrt_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop), .rsp_status(rsp_status),
   .rsp_hit_distance(rsp_hit_distance), .pready(pready)
);
`default_nettype wire
